// ===== design/sedec_pkg.sv =====
// shared types, byte codes and decode helpers for the string escape decoder
package sedec_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] count_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_ESCAPE = 3'b010,
      MODE_HEX    = 3'b100
   } mode_type;

   localparam byte_type CHAR_NUL       = 8'h00;
   localparam byte_type CHAR_BACKSLASH = 8'h5c;
   localparam byte_type CHAR_HEX_BYTE  = 8'h78;
   localparam byte_type CHAR_HEX_SHORT = 8'h75;
   localparam byte_type CHAR_HEX_LONG  = 8'h55;
   localparam byte_type CHAR_QUOTE     = 8'h22;

   localparam count_type DIGITS_BYTE  = 4'd2;
   localparam count_type DIGITS_SHORT = 4'd4;
   localparam count_type DIGITS_LONG  = 4'd8;

   function automatic byte_type escape_value(input byte_type b);
      byte_type v;
      unique case (b)
         8'h30: v = 8'h00;
         8'h61: v = 8'h07;
         8'h62: v = 8'h08;
         8'h66: v = 8'h0c;
         8'h6e: v = 8'h0a;
         8'h72: v = 8'h0d;
         8'h76: v = 8'h0b;
         8'h74: v = 8'h09;
         default: v = b;
      endcase
      return v;
   endfunction

   function automatic byte_type digit_value(input byte_type b);
      byte_type v;
      priority if (b >= 8'h41 && b <= 8'h5a) begin
         v = b - 8'd55;
      end else if (b >= 8'h61 && b <= 8'h7a) begin
         v = b - 8'd87;
      end else begin
         v = b - 8'd48;
      end
      return v;
   endfunction

endpackage

// ===== design/string_escape_decoder.sv =====
// string escape decoder top level: one raw byte in, one decoded result out
//
//   port group | dir | transfer when           | carries
//   req_       | in  | req_valid & !req_stall  | in_byte
//   rsp_       | out | rsp_valid & !rsp_stall  | byte_valid, out_byte, string_end
//   csr_       | in  | csr_valid & csr_ready   | terminator (csr_ready always high)
//
// one byte per cycle while req_stall is low; a result is registered and appears in the cycle after its request transfer
// decode state and result register update in the same cycle the byte is taken
// req_stall is high only while a result is held and rsp_stall is high
// synchronous active-high reset clears the mode, the result valid and sets terminator to 0x22
module string_escape_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sedec_pkg::byte_type req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_byte_valid,
   output sedec_pkg::byte_type rsp_out_byte,
   output logic               rsp_string_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  sedec_pkg::byte_type csr_data
);
   import sedec_pkg::*;

   mode_type  mode_ff, mode_in;
   count_type digits_ff, digits_in;
   byte_type  acc_ff, acc_in;
   byte_type  term_ff;
   logic      rsp_valid_ff;
   logic      byte_valid_ff, byte_valid_in;
   byte_type  out_byte_ff, out_byte_in;
   logic      end_ff, end_in;
   logic      accept;
   byte_type  b;
   byte_type  acc_next;
   count_type digits_dec;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign b         = req_in_byte;
   assign acc_next  = {acc_ff[3:0], 4'b0000} | digit_value(b);
   assign digits_dec = digits_ff - 4'd1;

   always_comb begin
      mode_in       = mode_ff;
      digits_in     = digits_ff;
      acc_in        = acc_ff;
      byte_valid_in = 1'b0;
      out_byte_in   = '0;
      end_in        = 1'b0;
      unique case (mode_ff)
         MODE_ESCAPE: begin
            priority if (b == CHAR_HEX_BYTE || b == CHAR_HEX_SHORT || b == CHAR_HEX_LONG) begin
               digits_in = (b == CHAR_HEX_BYTE)  ? DIGITS_BYTE :
                           (b == CHAR_HEX_SHORT) ? DIGITS_SHORT : DIGITS_LONG;
               acc_in    = '0;
               mode_in   = MODE_HEX;
            end else if (b == CHAR_NUL) begin
               byte_valid_in = 1'b1;
               out_byte_in   = CHAR_BACKSLASH;
               end_in        = 1'b1;
               mode_in       = MODE_NORMAL;
            end else begin
               byte_valid_in = 1'b1;
               out_byte_in   = escape_value(b);
               mode_in       = MODE_NORMAL;
            end
         end
         MODE_HEX: begin
            if (b == CHAR_NUL) begin
               end_in    = 1'b1;
               acc_in    = '0;
               digits_in = '0;
               mode_in   = MODE_NORMAL;
            end else begin
               acc_in = acc_next;
               if (digits_ff[0]) begin
                  byte_valid_in = 1'b1;
                  out_byte_in   = acc_next;
                  acc_in        = '0;
               end
               digits_in = digits_dec;
               if (digits_dec == '0) begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            priority if (b == term_ff || b == CHAR_NUL) begin
               end_in = 1'b1;
            end else if (b == CHAR_BACKSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               byte_valid_in = 1'b1;
               out_byte_in   = b;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         digits_ff    <= '0;
         acc_ff       <= '0;
         term_ff      <= CHAR_QUOTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            term_ff <= csr_data;
         end
         if (accept) begin
            mode_ff      <= mode_in;
            digits_ff    <= digits_in;
            acc_ff       <= acc_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_valid_ff <= byte_valid_in;
         out_byte_ff   <= out_byte_in;
         end_ff        <= end_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_string_end = end_ff;

endmodule

// ===== design/sedec_checker.sv =====
// port-level checks for the string escape decoder and their bind
module sedec_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input sedec_pkg::byte_type req_in_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_byte_valid,
   input sedec_pkg::byte_type rsp_out_byte,
   input logic               rsp_string_end
);
   import sedec_pkg::*;

   // held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_byte_valid) && $stable(rsp_out_byte)
         && $stable(rsp_string_end))
      else $error("held result changed");

   // no new transfer while a held result is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken over a stalled result");

   // a nul byte always ends the string in the next result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_in_byte == CHAR_NUL |=> rsp_valid && rsp_string_end)
      else $error("nul did not end the string");

   // empty result carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == '0)
      else $error("byte without valid is not zero");

endmodule

bind string_escape_decoder sedec_checker u_sedec_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_in_byte    (req_in_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_string_end (rsp_string_end)
);
